// ----- rtl/core/utf8d_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream decoder.
package utf8d_pkg;

   localparam int unsigned CodePointWidth = 31;
   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned CountWidth     = 3;
   localparam int unsigned BufCountWidth  = 2;

   localparam logic [ByteWidth-1:0] LeadTwoMin   = 8'hC0;
   localparam logic [ByteWidth-1:0] LeadThreeMin = 8'hE0;
   localparam logic [ByteWidth-1:0] LeadFourMin  = 8'hF0;
   localparam logic [ByteWidth-1:0] LeadFiveMin  = 8'hF8;
   localparam logic [ByteWidth-1:0] LeadSixMin   = 8'hFC;

   localparam logic [1:0] ContTag = 2'b10;

   localparam logic [BufCountWidth-1:0] BufEmpty = 2'd0;
   localparam logic [BufCountWidth-1:0] BufOne   = 2'd1;
   localparam logic [BufCountWidth-1:0] BufFull  = 2'd2;

   typedef struct packed {
      logic [CodePointWidth-1:0] code_point;
      logic                      truncated;
      logic [ByteWidth-1:0]      bad_byte;
   } result_type;

   // Number of continuation bytes announced by a lead byte; zero for any byte below 0xC0.
   function automatic logic [CountWidth-1:0] follower_count(input logic [ByteWidth-1:0] b);
      logic [CountWidth-1:0] n;
      if (b < LeadTwoMin) begin
         n = 3'd0;
      end else if (b < LeadThreeMin) begin
         n = 3'd1;
      end else if (b < LeadFourMin) begin
         n = 3'd2;
      end else if (b < LeadFiveMin) begin
         n = 3'd3;
      end else if (b < LeadSixMin) begin
         n = 3'd4;
      end else begin
         n = 3'd5;
      end
      return n;
   endfunction

endpackage

// ----- rtl/core/utf8d_channels.sv -----
// Handshake channel interfaces for the decoder's request and result sides.
interface utf8d_req_if;
   import utf8d_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_rsp_if;
   import utf8d_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CodePointWidth-1:0] code_point;
   logic                      truncated;
   logic [ByteWidth-1:0]      bad_byte;

   modport source (output valid, output code_point, output truncated, output bad_byte,
                   input ready);
   modport sink   (input valid, input code_point, input truncated, input bad_byte,
                   output ready);
endinterface

// ----- rtl/core/utf8d_core.sv -----
// Sequence state and per-byte decode logic: accumulator and pending continuation count.
module utf8d_core
   import utf8d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] in_byte,
   output logic                 emit,
   output result_type           result
);

   logic [CodePointWidth-1:0] accum_ff, accum_in;
   logic [CountWidth-1:0]     remaining_ff, remaining_in;
   logic [CountWidth-1:0]     lead_count;
   logic [CountWidth-1:0]     remaining_dec;
   logic [CodePointWidth-1:0] shifted;
   logic [CodePointWidth-1:0] padded;
   logic [ByteWidth-1:0]      lead_bits;
   logic                      is_cont;

   assign lead_count    = follower_count(in_byte);
   assign is_cont       = (in_byte[7:6] == ContTag);
   assign remaining_dec = remaining_ff - 3'd1;
   assign shifted       = {accum_ff[CodePointWidth-7:0], in_byte[5:0]};

   // Lead byte keeps its low (6 - count) bits.
   always_comb begin
      case (lead_count)
         3'd1:    lead_bits = in_byte & 8'h1F;
         3'd2:    lead_bits = in_byte & 8'h0F;
         3'd3:    lead_bits = in_byte & 8'h07;
         3'd4:    lead_bits = in_byte & 8'h03;
         default: lead_bits = in_byte & 8'h01;
      endcase
   end

   // A broken sequence is padded with one zero group per missing continuation byte.
   always_comb begin
      case (remaining_ff)
         3'd1:    padded = accum_ff << 6;
         3'd2:    padded = accum_ff << 12;
         3'd3:    padded = accum_ff << 18;
         3'd4:    padded = accum_ff << 24;
         3'd5:    padded = accum_ff << 30;
         default: padded = accum_ff;
      endcase
   end

   always_comb begin
      accum_in     = accum_ff;
      remaining_in = remaining_ff;
      emit         = 1'b0;
      result       = '0;
      if (remaining_ff == 3'd0) begin
         if (lead_count == 3'd0) begin
            accum_in          = {{(CodePointWidth-ByteWidth){1'b0}}, in_byte};
            emit              = 1'b1;
            result.code_point = {{(CodePointWidth-ByteWidth){1'b0}}, in_byte};
         end else begin
            accum_in     = {{(CodePointWidth-ByteWidth){1'b0}}, lead_bits};
            remaining_in = lead_count;
         end
      end else if (is_cont) begin
         accum_in          = shifted;
         remaining_in      = remaining_dec;
         emit              = (remaining_dec == 3'd0);
         result.code_point = shifted;
      end else begin
         accum_in          = padded;
         remaining_in      = 3'd0;
         emit              = 1'b1;
         result.code_point = padded;
         result.truncated  = 1'b1;
         result.bad_byte   = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         remaining_ff <= '0;
      end else if (step) begin
         accum_ff     <= accum_in;
         remaining_ff <= remaining_in;
      end
   end

   a_remaining_range: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= 3'd5)
      else $error("continuation count out of range");

   a_trunc_idles: assert property (@(posedge clock) disable iff (reset)
      (step && emit && result.truncated) |=> (remaining_ff == 3'd0))
      else $error("decoder not idle after truncated sequence");

   a_emit_when_done: assert property (@(posedge clock) disable iff (reset)
      (step && remaining_ff != 3'd0 && is_cont) |=>
         ((remaining_ff == 3'd0) == $past(emit)))
      else $error("emit does not match end of sequence");

endmodule

// ----- rtl/core/utf8_stream_decoder_top.sv -----
// UTF-8 stream decoder top level: request register, decode core and two-entry result buffer.
//
// Decodes one byte per clock into code points under the legacy rules (up to five
// continuation bytes, 31-bit code points). A byte is taken into a request register,
// decoded from there against the sequence state, and its result (if any) lands in a
// two-entry result buffer, whose head entry is presented on the result side.
// Throughput is one byte per clock while the request register is not stalled, as the
// accumulator and continuation count are updated once per accepted byte; the request side
// stalls only while both result entries are held and the byte waiting in the request
// register would emit.
// Lead bytes and inner continuation bytes produce no result. A byte that breaks an open
// sequence yields a zero-padded, flagged result carrying that byte, and is consumed.
module utf8_stream_decoder_top
   import utf8d_pkg::*;
(
   input logic         clock,
   input logic         reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);

   logic                     in_valid_ff;
   logic [ByteWidth-1:0]     in_byte_ff;
   logic                     fire;
   logic                     emit;
   logic                     push;
   logic                     pop;
   result_type               result;
   result_type               head_ff, tail_ff;
   logic [BufCountWidth-1:0] count_ff, count_in;

   assign fire            = in_valid_ff && (!emit || (count_ff != BufFull));
   assign req_bus.ready   = !in_valid_ff || fire;
   assign push            = fire && emit;
   assign rsp_bus.valid   = (count_ff != BufEmpty);
   assign pop             = rsp_bus.valid && rsp_bus.ready;

   assign rsp_bus.code_point = head_ff.code_point;
   assign rsp_bus.truncated  = head_ff.truncated;
   assign rsp_bus.bad_byte   = head_ff.bad_byte;

   utf8d_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .in_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= BufEmpty;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.in_byte;
      end
      case (count_ff)
         BufEmpty: begin
            if (push) begin
               head_ff <= result;
            end
         end
         BufOne: begin
            if (push && pop) begin
               head_ff <= result;
            end else if (push) begin
               tail_ff <= result;
            end
         end
         default: begin
            if (pop) begin
               head_ff <= tail_ff;
            end
         end
      endcase
   end

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BufFull)
      else $error("result buffer overfilled");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == BufFull) |-> !push)
      else $error("request pushed into full result buffer");

   a_bad_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.truncated) |-> (rsp_bus.bad_byte == 8'h00))
      else $error("bad byte reported without truncation");

   a_bad_not_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.truncated) |-> (rsp_bus.bad_byte[7:6] != ContTag))
      else $error("continuation byte reported as breaking byte");

endmodule

// ----- sim/utf8d_decode_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the decoder's code points from accepted requests and compares results.
module utf8d_decode_checker
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if        req_bus,
   utf8d_rsp_if        rsp_bus,
   output int unsigned mismatch_count,
   output int unsigned outstanding,
   output int unsigned results_checked,
   output int unsigned truncations_checked
);

   logic [CodePointWidth-1:0] partial_cp;
   logic [CountWidth-1:0]     bytes_left;
   result_type                code_points_due[$];
   result_type                due;

   // Advances the sequence state by one byte and queues the code point it completes, if any.
   task automatic decode_byte(input logic [ByteWidth-1:0] b);
      logic [CountWidth-1:0] lead_len;
      result_type            r;
      r = '0;
      if (bytes_left == 0) begin
         casez (b)
            8'b110?????: lead_len = 3'd1;
            8'b1110????: lead_len = 3'd2;
            8'b11110???: lead_len = 3'd3;
            8'b111110??: lead_len = 3'd4;
            8'b111111??: lead_len = 3'd5;
            default:     lead_len = 3'd0;
         endcase
         if (lead_len == 0) begin
            // Plain bytes and stray continuation bytes stand for themselves.
            partial_cp   = {{(CodePointWidth-ByteWidth){1'b0}}, b};
            r.code_point = partial_cp;
            code_points_due.push_back(r);
         end else begin
            partial_cp = b & ((31'd1 << (6 - lead_len)) - 31'd1);
            bytes_left = lead_len;
         end
      end else if (b[7:6] == ContTag) begin
         partial_cp = {partial_cp[CodePointWidth-7:0], b[5:0]};
         bytes_left = bytes_left - 3'd1;
         if (bytes_left == 0) begin
            r.code_point = partial_cp;
            code_points_due.push_back(r);
         end
      end else begin
         // The breaking byte is swallowed; missing six-bit groups read as zero.
         partial_cp   = partial_cp << (6 * bytes_left);
         bytes_left   = 3'd0;
         r.code_point = partial_cp;
         r.truncated  = 1'b1;
         r.bad_byte   = b;
         code_points_due.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         partial_cp          = '0;
         bytes_left          = '0;
         code_points_due.delete();
         mismatch_count      = 0;
         results_checked     = 0;
         truncations_checked = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (code_points_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, got code point %h trunc %b bad %h",
                        $time, rsp_bus.code_point, rsp_bus.truncated, rsp_bus.bad_byte);
               mismatch_count++;
            end else begin
               due = code_points_due.pop_front();
               results_checked++;
               if (due.truncated) truncations_checked++;
               if (rsp_bus.code_point !== due.code_point) begin
                  $display("%0t: code point mismatch: expected %h, got %h",
                           $time, due.code_point, rsp_bus.code_point);
                  mismatch_count++;
               end
               if (rsp_bus.truncated !== due.truncated) begin
                  $display("%0t: truncated flag mismatch: expected %b, got %b",
                           $time, due.truncated, rsp_bus.truncated);
                  mismatch_count++;
               end
               if (rsp_bus.bad_byte !== due.bad_byte) begin
                  $display("%0t: bad byte mismatch: expected %h, got %h",
                           $time, due.bad_byte, rsp_bus.bad_byte);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.in_byte);
         end
      end
      outstanding = code_points_due.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte stream stimulus with random idling, and the verdict.
module testbench;
   import utf8d_pkg::*;

   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned RandomBytes   = 750;
   localparam int unsigned IdlePercent   = 29;
   localparam int unsigned CalmStart     = 250;
   localparam int unsigned CalmEnd       = 450;
   localparam int unsigned DrainCycles   = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned idle_pct = IdlePercent;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned results_checked;
   int unsigned truncations_checked;

   logic [ByteWidth-1:0] directed_bytes[$];

   utf8d_req_if req_bus ();
   utf8d_rsp_if rsp_bus ();

   utf8_stream_decoder_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   utf8d_decode_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_bus             (req_bus),
      .rsp_bus             (rsp_bus),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding),
      .results_checked     (results_checked),
      .truncations_checked (truncations_checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  outstanding);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
   end

   // Offers one request, with a random gap first, and returns at the edge that accepts it.
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Mostly well-formed sequences of random length and content; some are cut short by a
   // non-continuation byte, and a few requests are plain noise.
   task automatic send_random_sequence();
      int unsigned          seq_len;
      int unsigned          keep;
      int unsigned          k;
      logic [ByteWidth-1:0] lead;
      if ($urandom_range(99) < 10) begin
         send_byte(ByteWidth'($urandom_range(255)));
         return;
      end
      seq_len = $urandom_range(5);
      case (seq_len)
         0: lead = ByteWidth'($urandom_range(8'hBF));
         1: lead = LeadTwoMin   | ByteWidth'($urandom_range(31));
         2: lead = LeadThreeMin | ByteWidth'($urandom_range(15));
         3: lead = LeadFourMin  | ByteWidth'($urandom_range(7));
         4: lead = LeadFiveMin  | ByteWidth'($urandom_range(3));
         default: lead = LeadSixMin | ByteWidth'($urandom_range(3));
      endcase
      send_byte(lead);
      if (seq_len == 0) return;
      keep = seq_len;
      if ($urandom_range(99) < 20) keep = $urandom_range(seq_len - 1);
      for (k = 0; k < keep; k++) begin
         send_byte({ContTag, 6'($urandom_range(63))});
      end
      if (keep < seq_len) begin
         if ($urandom_range(1) == 0) send_byte(ByteWidth'($urandom_range(127)));
         else send_byte(LeadTwoMin | ByteWidth'($urandom_range(63)));
      end
   endtask

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= '0;
      directed_bytes = {
         8'h00, 8'h7F, 8'h80, 8'hBF,                 // plain and stray continuation bytes
         8'hC2, 8'hA9,                               // two-byte sequence
         8'hEF, 8'hBF, 8'hBF,                        // three-byte sequence
         8'hF7, 8'hBF, 8'hBF, 8'hBF,                 // four-byte sequence
         8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,   // FF as six-byte lead, largest value
         8'hE2, 8'h82, 8'h41,                        // broken by a plain byte
         8'hFC, 8'h41,                               // broken right after the lead
         8'hF8, 8'h88, 8'hC3                         // broken by a lead byte, which is eaten
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      while (bytes_sent < directed_bytes.size() + RandomBytes) begin
         // A stretch in the middle runs both sides without any idling.
         if (bytes_sent >= CalmStart && bytes_sent < CalmEnd) idle_pct = 0;
         else idle_pct = IdlePercent;
         send_random_sequence();
      end
      idle_pct = IdlePercent;
      req_bus.valid <= 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d bytes, checked %0d code points, %0d of them from broken sequences.",
               bytes_sent, results_checked, truncations_checked);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_channels.sv
rtl/core/utf8d_core.sv
rtl/core/utf8_stream_decoder_top.sv
sim/utf8d_decode_checker.sv
sim/testbench.sv
